// ===== hdl/scfd_pkg.sv =====
// scfd_pkg: shared types, codes and item layouts of the serial command frame decoder
// no dependencies; used by every other file of the block except scfd_if
`timescale 1ns / 1ps

package scfd_pkg;

	localparam logic [7:0] START_CODE_RST = 8'h53;
	localparam logic [7:0] STOP_CODE_RST  = 8'hAA;

	// register indexes of the configuration port
	localparam logic CFG_START = 1'b0;
	localparam logic CFG_STOP  = 1'b1;

	// instruction codes
	localparam logic [7:0] READ_LIMIT  = 8'h0A;
	localparam logic [7:0] CMD_CHECK   = 8'h00;
	localparam logic [7:0] CMD_PINS    = 8'h01;
	localparam logic [7:0] CMD_POT1    = 8'h02;
	localparam logic [7:0] CMD_POT2    = 8'h03;
	localparam logic [7:0] CMD_TEMP    = 8'h04;
	localparam logic [7:0] CMD_LIGHT   = 8'h05;
	localparam logic [7:0] CMD_LED     = 8'h0A;
	localparam logic [7:0] CMD_HEATER  = 8'h0B;
	localparam logic [7:0] CMD_LAMP    = 8'h0C;
	localparam logic [7:0] CMD_MOTOR   = 8'h0D;
	localparam logic [7:0] CHECK_REPLY = 8'h0F;

	typedef enum logic [2:0] {
		PS_IDLE  = 3'd0,
		PS_INSTR = 3'd1,
		PS_LOW   = 3'd2,
		PS_HIGH  = 3'd3,
		PS_STOP  = 3'd4
	} parse_state_t;

	typedef enum logic [1:0] {
		AK_READ  = 2'd0,
		AK_WRITE = 2'd1,
		AK_NONE  = 2'd2
	} access_kind_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic [7:0] switch_pins;
		logic [7:0] pot1_sample;
		logic [7:0] pot2_sample;
		logic [7:0] temp_sample;
		logic [7:0] light_sample;
	} cmd_item_t;

	typedef struct packed {
		logic [7:0]  reply_byte;
		logic [7:0]  led_value;
		logic [15:0] heater_duty;
		logic [15:0] lamp_duty;
		logic [15:0] motor_duty;
	} rsp_item_t;

	// parser status toward the top level
	typedef struct packed {
		logic         reply;
		parse_state_t state;
	} parse_status_t;

endpackage

// ===== hdl/scfd_if.sv =====
// scfd_if: valid/ready channel interfaces for command items and reply items
// depends on nothing; field names follow the item layouts in scfd_pkg
`timescale 1ns / 1ps

interface scfd_cmd_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic [7:0] switch_pins;
	logic [7:0] pot1_sample;
	logic [7:0] pot2_sample;
	logic [7:0] temp_sample;
	logic [7:0] light_sample;

	modport source (
		output valid, rx_byte, switch_pins, pot1_sample, pot2_sample,
		temp_sample, light_sample,
		input  ready
	);
	modport sink (
		input  valid, rx_byte, switch_pins, pot1_sample, pot2_sample,
		temp_sample, light_sample,
		output ready
	);
endinterface

interface scfd_rsp_if;
	logic        valid;
	logic        ready;
	logic [7:0]  reply_byte;
	logic [7:0]  led_value;
	logic [15:0] heater_duty;
	logic [15:0] lamp_duty;
	logic [15:0] motor_duty;

	modport source (
		output valid, reply_byte, led_value, heater_duty, lamp_duty, motor_duty,
		input  ready
	);
	modport sink (
		input  valid, reply_byte, led_value, heater_duty, lamp_duty, motor_duty,
		output ready
	);
endinterface

// ===== hdl/scfd_parser.sv =====
// scfd_parser: frame state machine, command decode and actuator registers
// depends on scfd_pkg
`timescale 1ns / 1ps

module scfd_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  scfd_pkg::cmd_item_t   item,
	input  logic [7:0]            start_code,
	input  logic [7:0]            stop_code,
	output scfd_pkg::parse_status_t status,
	output scfd_pkg::rsp_item_t   result
);

	scfd_pkg::parse_state_t state_q, state_d;
	scfd_pkg::access_kind_t kind_q, kind_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [7:0]  low_q, low_d;
	logic [15:0] word_q, word_d;
	logic [7:0]  led_q, led_d;
	logic [15:0] heater_q, heater_d;
	logic [15:0] lamp_q, lamp_d;
	logic [15:0] motor_q, motor_d;
	logic        reply;
	logic [7:0]  reply_byte;
	logic        stop_ok;

	assign stop_ok = (item.rx_byte == stop_code);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			scfd_pkg::PS_IDLE: begin
				if (item.rx_byte == start_code) state_d = scfd_pkg::PS_INSTR;
			end
			scfd_pkg::PS_INSTR: begin
				state_d = (item.rx_byte < scfd_pkg::READ_LIMIT) ? scfd_pkg::PS_STOP
					: scfd_pkg::PS_LOW;
			end
			scfd_pkg::PS_LOW:  state_d = scfd_pkg::PS_HIGH;
			scfd_pkg::PS_HIGH: state_d = scfd_pkg::PS_STOP;
			scfd_pkg::PS_STOP: state_d = scfd_pkg::PS_IDLE;
			default:           state_d = scfd_pkg::PS_IDLE;
		endcase
	end

	// frame fields, actuator writes and reply
	always_comb begin
		kind_d     = kind_q;
		cmd_d      = cmd_q;
		low_d      = low_q;
		word_d     = word_q;
		led_d      = led_q;
		heater_d   = heater_q;
		lamp_d     = lamp_q;
		motor_d    = motor_q;
		reply      = 1'b0;
		reply_byte = 8'h00;
		unique case (state_q)
			scfd_pkg::PS_IDLE: begin
				cmd_d  = 8'h00;
				kind_d = scfd_pkg::AK_NONE;
				low_d  = 8'h00;
			end
			scfd_pkg::PS_INSTR: begin
				cmd_d = item.rx_byte;
				if (item.rx_byte < scfd_pkg::READ_LIMIT) kind_d = scfd_pkg::AK_READ;
			end
			scfd_pkg::PS_LOW: begin
				low_d = item.rx_byte;
			end
			scfd_pkg::PS_HIGH: begin
				word_d = {item.rx_byte, low_q};
				kind_d = scfd_pkg::AK_WRITE;
			end
			scfd_pkg::PS_STOP: begin
				if (stop_ok && kind_q == scfd_pkg::AK_READ) begin
					reply = 1'b1;
					unique case (cmd_q)
						scfd_pkg::CMD_CHECK: reply_byte = scfd_pkg::CHECK_REPLY;
						scfd_pkg::CMD_PINS:  reply_byte = item.switch_pins;
						scfd_pkg::CMD_POT1:  reply_byte = item.pot1_sample;
						scfd_pkg::CMD_POT2:  reply_byte = item.pot2_sample;
						scfd_pkg::CMD_TEMP:  reply_byte = item.temp_sample;
						scfd_pkg::CMD_LIGHT: reply_byte = item.light_sample;
						default:             reply      = 1'b0;
					endcase
				end else if (stop_ok && kind_q == scfd_pkg::AK_WRITE) begin
					reply      = 1'b1;
					reply_byte = cmd_q;
					unique case (cmd_q)
						scfd_pkg::CMD_LED:    led_d    = low_q;
						scfd_pkg::CMD_HEATER: heater_d = word_q;
						scfd_pkg::CMD_LAMP:   lamp_d   = word_q;
						scfd_pkg::CMD_MOTOR:  motor_d  = word_q;
						default:              reply    = 1'b0;
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= scfd_pkg::PS_IDLE;
			kind_q   <= scfd_pkg::AK_NONE;
			cmd_q    <= 8'h00;
			low_q    <= 8'h00;
			word_q   <= 16'h0000;
			led_q    <= 8'h00;
			heater_q <= 16'h0000;
			lamp_q   <= 16'h0000;
			motor_q  <= 16'h0000;
		end else if (advance) begin
			state_q  <= state_d;
			kind_q   <= kind_d;
			cmd_q    <= cmd_d;
			low_q    <= low_d;
			word_q   <= word_d;
			led_q    <= led_d;
			heater_q <= heater_d;
			lamp_q   <= lamp_d;
			motor_q  <= motor_d;
		end
	end

	assign status.reply = reply;
	assign status.state = state_q;

	assign result.reply_byte  = reply_byte;
	assign result.led_value   = led_d;
	assign result.heater_duty = heater_d;
	assign result.lamp_duty   = lamp_d;
	assign result.motor_duty  = motor_d;

endmodule

// ===== hdl/scfd_out_stage.sv =====
// scfd_out_stage: reply output register driving the reply channel
// depends on scfd_pkg and scfd_rsp_if
`timescale 1ns / 1ps

module scfd_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  scfd_pkg::rsp_item_t data,
	output logic                can_take,
	scfd_rsp_if.source          rsp
);

	logic                valid_q;
	scfd_pkg::rsp_item_t data_q;

	// free when empty or when the held reply leaves this cycle
	assign can_take = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) data_q <= data;
	end

	assign rsp.valid       = valid_q;
	assign rsp.reply_byte  = data_q.reply_byte;
	assign rsp.led_value   = data_q.led_value;
	assign rsp.heater_duty = data_q.heater_duty;
	assign rsp.lamp_duty   = data_q.lamp_duty;
	assign rsp.motor_duty  = data_q.motor_duty;

endmodule

// ===== hdl/serial_command_frame_decoder.sv =====
// serial_command_frame_decoder: top level, input register, config registers, parser, reply stage
// depends on scfd_pkg, scfd_if, scfd_parser and scfd_out_stage
`timescale 1ns / 1ps

//  channel  | dir | payload                                               | transfer
//  ---------+-----+-------------------------------------------------------+-------------------
//  cmd      | in  | rx_byte, switch_pins, pot1/pot2/temp/light_sample     | valid & ready
//  rsp      | out | reply_byte, led_value, heater/lamp/motor_duty         | valid & ready
//  cfg      | in  | cfg_wr_en, cfg_index (0 start code, 1 stop code), data | cfg_wr_en high
//
// one byte per cycle while no reply is stalled: a transfer lands in the input register,
// then, once the reply register can take a result, the parser step (one state machine
// update and decode) runs and any reply is loaded into the reply register
// reset clears the parser to idle, zeroes the actuator values and loads the
// default start and stop codes
// a stalled reply holds the reply register; the next byte waits in the input
// register and cmd.ready stays low until the held reply leaves

module serial_command_frame_decoder (
	input  logic        clk,
	input  logic        arst_n,
	scfd_cmd_if.sink    cmd,
	scfd_rsp_if.source  rsp,
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);

	// configuration registers
	logic [7:0] start_code_q;
	logic [7:0] stop_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_code_q <= scfd_pkg::START_CODE_RST;
			stop_code_q  <= scfd_pkg::STOP_CODE_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				scfd_pkg::CFG_START: start_code_q <= cfg_data;
				scfd_pkg::CFG_STOP:  stop_code_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// input register stage
	logic                    valid_s1;
	scfd_pkg::cmd_item_t     item_s1;
	logic                    advance;
	logic                    out_free;
	logic                    cmd_take;
	scfd_pkg::parse_status_t pstat;
	scfd_pkg::rsp_item_t     presult;
	logic                    rsp_load;

	// the held byte steps the parser once the reply register can absorb its result
	assign advance  = valid_s1 && out_free;
	assign cmd.ready = !valid_s1 || advance;
	assign cmd_take = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			item_s1.rx_byte      <= cmd.rx_byte;
			item_s1.switch_pins  <= cmd.switch_pins;
			item_s1.pot1_sample  <= cmd.pot1_sample;
			item_s1.pot2_sample  <= cmd.pot2_sample;
			item_s1.temp_sample  <= cmd.temp_sample;
			item_s1.light_sample <= cmd.light_sample;
		end
	end

	scfd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.item       (item_s1),
		.start_code (start_code_q),
		.stop_code  (stop_code_q),
		.status     (pstat),
		.result     (presult)
	);

	assign rsp_load = advance && pstat.reply;

	scfd_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (rsp_load),
		.data     (presult),
		.can_take (out_free),
		.rsp      (rsp)
	);

	// replies only come out of the stop state
	a_reply_at_stop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |-> pstat.state == scfd_pkg::PS_STOP)
		else $error("reply loaded outside the stop state");

	// a loaded reply is offered on the next cycle
	a_reply_offered: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |=> rsp.valid)
		else $error("loaded reply not offered");

	// backpressure only while a byte is held behind a stalled reply
	a_ready_low_held: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ready |-> valid_s1 && rsp.valid && !rsp.ready)
		else $error("command channel stalled without cause");

endmodule

// ===== verif/scfd_frame_checker.sv =====
// scfd_frame_checker: watches the command, reply and config ports, predicts every reply
// depends on scfd_pkg and the channel interfaces in scfd_if; reports a failure count
`timescale 1ns / 1ps

module scfd_frame_checker
	import scfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	scfd_cmd_if        cmd,
	scfd_rsp_if        rsp,
	input  logic       cfg_wr_en,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	output int         fail_count,
	output int         pending
);

	logic [7:0]   start_cd;
	logic [7:0]   stop_cd;
	parse_state_t ps;
	access_kind_t ak;
	logic [7:0]   code;
	logic [7:0]   lo_byte;
	logic [15:0]  word;
	logic [7:0]   led;
	logic [15:0]  heater;
	logic [15:0]  lamp;
	logic [15:0]  motor;
	rsp_item_t    replies_due[$];

	// one parser step; returns high when the byte closes a frame that gets a reply
	function automatic logic parse_byte(input cmd_item_t it, output rsp_item_t r);
		logic sent;
		sent = 1'b0;
		r = '0;
		case (ps)
			PS_IDLE: begin
				code = '0;
				ak = AK_NONE;
				lo_byte = '0;
				if (it.rx_byte == start_cd)
					ps = PS_INSTR;
			end
			PS_INSTR: begin
				code = it.rx_byte;
				if (it.rx_byte < READ_LIMIT) begin
					ak = AK_READ;
					ps = PS_STOP;
				end else begin
					ps = PS_LOW;
				end
			end
			PS_LOW: begin
				lo_byte = it.rx_byte;
				ps = PS_HIGH;
			end
			PS_HIGH: begin
				word = {it.rx_byte, lo_byte};
				ak = AK_WRITE;
				ps = PS_STOP;
			end
			PS_STOP: begin
				if (it.rx_byte == stop_cd) begin
					if (ak == AK_READ) begin
						sent = 1'b1;
						case (code)
							CMD_CHECK: r.reply_byte = CHECK_REPLY;
							CMD_PINS:  r.reply_byte = it.switch_pins;
							CMD_POT1:  r.reply_byte = it.pot1_sample;
							CMD_POT2:  r.reply_byte = it.pot2_sample;
							CMD_TEMP:  r.reply_byte = it.temp_sample;
							CMD_LIGHT: r.reply_byte = it.light_sample;
							default:   sent = 1'b0;
						endcase
					end else if (ak == AK_WRITE) begin
						sent = 1'b1;
						r.reply_byte = code;
						case (code)
							CMD_LED:    led = lo_byte;
							CMD_HEATER: heater = word;
							CMD_LAMP:   lamp = word;
							CMD_MOTOR:  motor = word;
							default:    sent = 1'b0;
						endcase
					end
				end
				ps = PS_IDLE;
			end
			default: ps = PS_IDLE;
		endcase
		r.led_value = led;
		r.heater_duty = heater;
		r.lamp_duty = lamp;
		r.motor_duty = motor;
		return sent;
	endfunction

	function automatic void note_fail(input string what, input rsp_item_t want,
		input rsp_item_t got);
		fail_count++;
		if (fail_count <= 10)
			$display("[%0t] %s: want reply=%h led=%h heater=%h lamp=%h motor=%h, got reply=%h led=%h heater=%h lamp=%h motor=%h",
				$time, what, want.reply_byte, want.led_value, want.heater_duty,
				want.lamp_duty, want.motor_duty, got.reply_byte, got.led_value,
				got.heater_duty, got.lamp_duty, got.motor_duty);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cmd_item_t it;
		rsp_item_t got;
		rsp_item_t want;
		if (!arst_n) begin
			start_cd = START_CODE_RST;
			stop_cd = STOP_CODE_RST;
			ps = PS_IDLE;
			ak = AK_NONE;
			code = '0;
			lo_byte = '0;
			word = '0;
			led = '0;
			heater = '0;
			lamp = '0;
			motor = '0;
			replies_due.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index == CFG_START)
					start_cd = cfg_data;
				else
					stop_cd = cfg_data;
			end
			if (rsp.valid && rsp.ready) begin
				got.reply_byte = rsp.reply_byte;
				got.led_value = rsp.led_value;
				got.heater_duty = rsp.heater_duty;
				got.lamp_duty = rsp.lamp_duty;
				got.motor_duty = rsp.motor_duty;
				if (replies_due.size() == 0) begin
					note_fail("reply with none due", '0, got);
				end else begin
					want = replies_due.pop_front();
					if (got.reply_byte != want.reply_byte ||
						got.led_value != want.led_value ||
						got.heater_duty != want.heater_duty ||
						got.lamp_duty != want.lamp_duty ||
						got.motor_duty != want.motor_duty)
						note_fail("reply mismatch", want, got);
				end
			end
			if (cmd.valid && cmd.ready) begin
				it.rx_byte = cmd.rx_byte;
				it.switch_pins = cmd.switch_pins;
				it.pot1_sample = cmd.pot1_sample;
				it.pot2_sample = cmd.pot2_sample;
				it.temp_sample = cmd.temp_sample;
				it.light_sample = cmd.light_sample;
				if (parse_byte(it, want))
					replies_due.push_back(want);
			end
			pending = replies_due.size();
		end
	end

endmodule

// ===== verif/tb_serial_command_frame_decoder.sv =====
// tb_serial_command_frame_decoder: stimulus and verdict for the serial command frame decoder
// depends on scfd_pkg, scfd_if, the block itself and scfd_frame_checker
`timescale 1ns / 1ps

module tb_serial_command_frame_decoder;
	import scfd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_LEN    = 300;   // long reply stall to back the block up
	localparam int SETTLE      = 12;    // margin for the last reply to show after its byte
	localparam int PHASE_ITEMS = 400;

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic       cfg_index;
	logic [7:0] cfg_data;
	int         fail_count;
	int         pending;

	// idle and stall odds in percent, changed per phase
	int gap_pct;
	int stall_pct;
	// long hold-off: main bumps the request, the ready process counts it out
	int hold_req;
	int hold_seen;
	int hold_left;
	int cycles;
	int frame_items;

	// the codes the frames are built with, mirrors what was written to the block
	logic [7:0] start_cd;
	logic [7:0] stop_cd;

	scfd_cmd_if cmd_ch ();
	scfd_rsp_if rsp_ch ();

	serial_command_frame_decoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch.sink),
		.rsp       (rsp_ch.source),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	scfd_frame_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_ch),
		.rsp        (rsp_ch),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog on total run length
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// reply side: random stalls, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// one byte transfer; random idle cycles go in front of it
	// valid stays high between back-to-back bytes so it is never dropped and raised in one step
	task automatic push_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < gap_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.rx_byte <= b;
		cmd_ch.switch_pins <= 8'($urandom_range(0, 255));
		cmd_ch.pot1_sample <= 8'($urandom_range(0, 255));
		cmd_ch.pot2_sample <= 8'($urandom_range(0, 255));
		cmd_ch.temp_sample <= 8'($urandom_range(0, 255));
		cmd_ch.light_sample <= 8'($urandom_range(0, 255));
		do @(posedge clk); while (!cmd_ch.ready);
	endtask

	// start, instruction, data bytes for writes, then the given closing byte
	task automatic send_frame(input logic [7:0] op, input logic [15:0] data,
		input logic [7:0] close);
		push_byte(start_cd);
		push_byte(op);
		frame_items += 3;
		if (op >= READ_LIMIT) begin
			push_byte(data[7:0]);
			push_byte(data[15:8]);
			frame_items += 2;
		end
		push_byte(close);
	endtask

	// mostly well-formed frames with random content, some broken ones and some noise
	task automatic random_frame();
		int pick;
		logic [7:0] op;
		logic [15:0] data;
		pick = $urandom_range(0, 99);
		case ($urandom_range(0, 9))
			0: data = 16'h0000;
			1: data = 16'hFFFF;
			default: data = 16'($urandom_range(0, 16'hFFFF));
		endcase
		if (pick < 40) begin
			// reads, now and then an unknown read code
			if ($urandom_range(0, 9) < 8)
				op = 8'($urandom_range(CMD_CHECK, CMD_LIGHT));
			else
				op = 8'($urandom_range(CMD_LIGHT + 1, READ_LIMIT - 1));
			send_frame(op, data, stop_cd);
		end else if (pick < 80) begin
			// writes, now and then an unknown write code up to 0xff
			if ($urandom_range(0, 9) < 8)
				op = 8'($urandom_range(CMD_LED, CMD_MOTOR));
			else
				op = 8'($urandom_range(CMD_MOTOR + 1, 8'hFF));
			send_frame(op, data, stop_cd);
		end else if (pick < 88) begin
			// wrong closing byte, any instruction
			send_frame(8'($urandom_range(0, 255)), data,
				stop_cd ^ 8'($urandom_range(1, 255)));
		end else if (pick < 94) begin
			// a stray byte that is not the start code, ignored by the parser while idle
			push_byte(start_cd ^ 8'($urandom_range(1, 255)));
		end else begin
			// cut-off frame; the next frame's bytes run into it
			push_byte(start_cd);
			push_byte(8'($urandom_range(0, 255)));
			frame_items += 2;
		end
	endtask

	task automatic run_random(input int n);
		int goal;
		goal = frame_items + n;
		while (frame_items < goal)
			random_frame();
	endtask

	// sender goes quiet until every reply is back and the pipeline is empty
	task automatic drain();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// both code registers, back to back, only with the block idle
	task automatic set_codes(input logic [7:0] s, input logic [7:0] p);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_START;
		cfg_data <= s;
		@(posedge clk);
		cfg_index <= CFG_STOP;
		cfg_data <= p;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		start_cd = s;
		stop_cd = p;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_START;
		cfg_data = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.rx_byte = '0;
		cmd_ch.switch_pins = '0;
		cmd_ch.pot1_sample = '0;
		cmd_ch.pot2_sample = '0;
		cmd_ch.temp_sample = '0;
		cmd_ch.light_sample = '0;
		rsp_ch.ready = 1'b0;
		gap_pct = 0;
		stall_pct = 0;
		hold_req = 0;
		hold_seen = 0;
		hold_left = 0;
		cycles = 0;
		frame_items = 0;
		start_cd = START_CODE_RST;
		stop_cd = STOP_CODE_RST;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames under the reset codes, no idling on either side
		send_frame(CMD_CHECK, 16'h0000, stop_cd);
		send_frame(CMD_HEATER, 16'hFFFF, stop_cd);
		// led write takes only the low data byte
		send_frame(CMD_LED, 16'h00FF, stop_cd);
		// unknown read code right below the write range: no reply
		send_frame(READ_LIMIT - 8'd1, 16'h0000, stop_cd);
		// unknown write code at the top of the byte range: no reply
		send_frame(8'hFF, 16'h1234, stop_cd);
		// wrong closing byte drops the frame
		send_frame(CMD_PINS, 16'h0000, ~stop_cd);

		// back-pressure: reply side holds off while reads keep coming
		hold_req++;
		repeat (40)
			send_frame(8'($urandom_range(CMD_CHECK, CMD_LIGHT)), 16'h0000, stop_cd);
		drain();
		run_random(PHASE_ITEMS);

		// extremes of the code registers, sender idling
		set_codes(8'h00, 8'hFF);
		gap_pct = 46;
		stall_pct = 0;
		run_random(PHASE_ITEMS);

		// swapped extremes, receiver stalling
		set_codes(8'hFF, 8'h00);
		gap_pct = 0;
		stall_pct = 46;
		run_random(PHASE_ITEMS);

		// random codes, both sides idling
		set_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		gap_pct = 37;
		stall_pct = 37;
		run_random(PHASE_ITEMS);

		drain();
		if (fail_count == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== serial_command_frame_decoder.f =====
hdl/scfd_pkg.sv
hdl/scfd_if.sv
hdl/scfd_parser.sv
hdl/scfd_out_stage.sv
hdl/serial_command_frame_decoder.sv
verif/scfd_frame_checker.sv
verif/tb_serial_command_frame_decoder.sv
